@@ sv/mbr_pkg.sv @@
// shared types and constants for the msb-first bit reader
`default_nettype none
package mbr_pkg;

   localparam int BUF_BYTES      = 4096;
   localparam int ADDR_W         = $clog2(BUF_BYTES);
   localparam int LEN_W          = 13;
   localparam int POS_W          = 16;
   localparam int MAX_FIELD_BITS = 32;
   localparam int VALUE_W        = 32;
   localparam int COUNT_W        = 6;
   localparam int BYTE_W         = 8;
   localparam int ACC_W          = MAX_FIELD_BITS + BYTE_W;
   localparam int NB_W           = 3;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_READ    = 2'd1,
      CMD_PEEK    = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FETCH,
      ST_LAST,
      ST_UPDATE,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic fetch;
      logic update;
      logic respond;
   } dp_ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic need_fetch;
      logic last_issue;
   } dp_stat_type;

endpackage
`default_nettype wire

@@ sv/msb_first_bit_reader_unit.sv @@
// top level of the msb-first bit reader
// flow: load, restart and rejected requests skip the byte fetch;
//   read and peek fetch the n bytes the field touches (n is 1 to 5)
// throughput: one request at a time, the next start is taken the cycle the result shows;
//   the byte store read port, one byte per cycle, sets the read and peek time
// reset: synchronous, clears position and buffer length; the store is not cleared
`default_nettype none
module msb_first_bit_reader_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire [1:0]                            req_command,
   input  wire [mbr_pkg::ADDR_W-1:0]            req_load_address,
   input  wire [mbr_pkg::BYTE_W-1:0]            req_load_byte,
   input  wire [mbr_pkg::COUNT_W-1:0]           req_bit_count,
   input  wire                                  csr_wr_en,
   input  wire [mbr_pkg::LEN_W-1:0]             csr_wr_data,
   output logic                                 rsp_valid,
   output logic [mbr_pkg::VALUE_W-1:0]          rsp_bits_value,
   output logic                                 rsp_bad_count,
   output logic                                 rsp_underflow,
   output logic                                 rsp_byte_aligned,
   output logic [mbr_pkg::POS_W-1:0]            rsp_total_bits_read,
   output logic [mbr_pkg::POS_W-1:0]            rsp_total_bits_left
);
   import mbr_pkg::*;

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   mbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   mbr_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .stat                (stat),
      .req_command         (req_command),
      .req_load_address    (req_load_address),
      .req_load_byte       (req_load_byte),
      .req_bit_count       (req_bit_count),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_bits_value      (rsp_bits_value),
      .rsp_bad_count       (rsp_bad_count),
      .rsp_underflow       (rsp_underflow),
      .rsp_byte_aligned    (rsp_byte_aligned),
      .rsp_total_bits_read (rsp_total_bits_read),
      .rsp_total_bits_left (rsp_total_bits_left)
   );

endmodule
`default_nettype wire

@@ sv/mbr_ctrl.sv @@
// controller state machine for the bit reader
`default_nettype none
module mbr_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  mbr_pkg::dp_stat_type stat,
   output mbr_pkg::dp_ctrl_type ctrl
);
   import mbr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_RESP);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_EVAL;
         ST_EVAL:   state_in = stat.need_fetch ? ST_FETCH : ST_UPDATE;
         ST_FETCH:  if (stat.last_issue) state_in = ST_LAST;
         ST_LAST:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE:   ctrl.capture = start;
         ST_EVAL:   ctrl.eval    = 1'b1;
         ST_FETCH:  ctrl.fetch   = 1'b1;
         ST_UPDATE: ctrl.update  = 1'b1;
         ST_RESP:   ctrl.respond = 1'b1;
         default:   ctrl = '0;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ sv/mbr_dp.sv @@
// datapath of the bit reader: byte store, position, fetch and extraction
`default_nettype none
module mbr_dp (
   input  wire                                  clock,
   input  wire                                  reset,
   input  mbr_pkg::dp_ctrl_type                 ctrl,
   output mbr_pkg::dp_stat_type                 stat,
   input  wire [1:0]                            req_command,
   input  wire [mbr_pkg::ADDR_W-1:0]            req_load_address,
   input  wire [mbr_pkg::BYTE_W-1:0]            req_load_byte,
   input  wire [mbr_pkg::COUNT_W-1:0]           req_bit_count,
   input  wire                                  csr_wr_en,
   input  wire [mbr_pkg::LEN_W-1:0]             csr_wr_data,
   output logic [mbr_pkg::VALUE_W-1:0]          rsp_bits_value,
   output logic                                 rsp_bad_count,
   output logic                                 rsp_underflow,
   output logic                                 rsp_byte_aligned,
   output logic [mbr_pkg::POS_W-1:0]            rsp_total_bits_read,
   output logic [mbr_pkg::POS_W-1:0]            rsp_total_bits_left
);
   import mbr_pkg::*;

   logic [BYTE_W-1:0]  mem [BUF_BYTES];

   cmd_type            cmd_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [ADDR_W-1:0]  ld_addr_ff;
   logic [BYTE_W-1:0]  ld_byte_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [POS_W-1:0]   pos_ff;
   logic               bad_ff, under_ff, ok_ff;
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic [NB_W-1:0]    nb_ff, k_ff;
   logic [2:0]         tail_ff;
   logic [BYTE_W-1:0]  rd_data_ff;
   logic               rd_vld_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [VALUE_W-1:0] value_ff;

   logic [POS_W-1:0]   avail, left;
   logic               is_field, bad, under;
   logic [COUNT_W-1:0] span;
   logic [ACC_W-1:0]   shifted;
   logic [VALUE_W:0]   mask;
   logic [VALUE_W-1:0] extracted;

   // lengths above the store count as the whole store
   always_comb begin
      if (len_ff > LEN_W'(BUF_BYTES)) avail = POS_W'(BUF_BYTES) << 3;
      else                            avail = POS_W'(len_ff) << 3;
      left = (avail > pos_ff) ? (avail - pos_ff) : '0;
   end

   assign is_field = (cmd_ff == CMD_READ) || (cmd_ff == CMD_PEEK);
   assign bad      = is_field && ((count_ff == '0) || (count_ff > COUNT_W'(MAX_FIELD_BITS)));
   assign under    = is_field && !bad && (POS_W'(count_ff) > left);
   assign span     = COUNT_W'(pos_ff[2:0]) + count_ff;

   assign stat.need_fetch = is_field && !bad && !under;
   assign stat.last_issue = (k_ff == (nb_ff - NB_W'(1)));

   // tail bits of the last fetched byte are dropped, then the field is masked
   assign shifted   = acc_ff >> tail_ff;
   assign mask      = ((VALUE_W+1)'(1) << count_ff) - (VALUE_W+1)'(1);
   assign extracted = shifted[VALUE_W-1:0] & mask[VALUE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (csr_wr_en) begin
         len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff     <= cmd_type'(req_command);
         count_ff   <= req_bit_count;
         ld_addr_ff <= req_load_address;
         ld_byte_ff <= req_load_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.eval && (cmd_ff == CMD_LOAD)) begin
         mem[ld_addr_ff] <= ld_byte_ff;
      end
      if (ctrl.fetch) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= ctrl.fetch;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.eval) begin
         bad_ff     <= bad;
         under_ff   <= under;
         ok_ff      <= stat.need_fetch;
         rd_addr_ff <= pos_ff[ADDR_W+2:3];
         nb_ff      <= NB_W'((span + COUNT_W'(7)) >> 3);
         tail_ff    <= 3'd0 - span[2:0];
         k_ff       <= '0;
      end else if (ctrl.fetch) begin
         rd_addr_ff <= rd_addr_ff + ADDR_W'(1);
         k_ff       <= k_ff + NB_W'(1);
      end
      if (rd_vld_ff) begin
         acc_ff <= {acc_ff[ACC_W-BYTE_W-1:0], rd_data_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (ctrl.update) begin
         if (cmd_ff == CMD_RESTART)              pos_ff <= '0;
         else if ((cmd_ff == CMD_READ) && ok_ff) pos_ff <= pos_ff + POS_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         if (bad_ff)     value_ff <= '1;
         else if (ok_ff) value_ff <= extracted;
         else            value_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.respond) begin
         rsp_bits_value      <= value_ff;
         rsp_bad_count       <= bad_ff;
         rsp_underflow       <= under_ff;
         rsp_byte_aligned    <= (pos_ff[2:0] == 3'd0);
         rsp_total_bits_read <= pos_ff;
         rsp_total_bits_left <= left;
      end
   end

endmodule
`default_nettype wire

@@ sv/mbr_checker.sv @@
// port-level checks for the bit reader, bound to the top level
`default_nettype none
module mbr_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              start,
   input wire                              busy,
   input wire                              rsp_valid,
   input wire [mbr_pkg::VALUE_W-1:0]       rsp_bits_value,
   input wire                              rsp_bad_count,
   input wire                              rsp_underflow
);
   import mbr_pkg::*;

   // a bad count is reported ahead of underflow, never both
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_bad_count && rsp_underflow))
      else $error("bad_count and underflow both set");

   a_bad_all_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_count) |-> (rsp_bits_value == '1))
      else $error("bad count result is not all ones");

   a_under_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_underflow) |-> (rsp_bits_value == '0))
      else $error("underflow result is not zero");

   // one request in flight, so strobes never come back to back
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes back to back");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

endmodule

bind msb_first_bit_reader_unit mbr_checker u_mbr_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_bits_value (rsp_bits_value),
   .rsp_bad_count  (rsp_bad_count),
   .rsp_underflow  (rsp_underflow)
);
`default_nettype wire
